/* hdl/hsif_pkg.sv */
package hsif_pkg;

  localparam int KEY_W     = 32;
  // bucket remainder steps: multiply by the reciprocal, multiply back, subtract
  localparam int DIV_STEPS = 3;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // operation codes on in_kind
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_FIND   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_LOOK,
    ST_CMP
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_we;        // clear one valid row
    logic accept;        // capture the input item
    logic addr_from_in;  // read the bucket row addressed by the input key
    logic div_step;      // advance the bucket remainder by one step
    logic commit;        // write back the row and load the result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;      // last row of the clearing pass
    logic div_last;      // last remainder step
    logic hash_direct;   // bucket count is a power of two
    logic out_busy;      // result register full and stalled
  } ctrl_status_t;

endpackage

/* hdl/hash_set_insert_find_core.sv */
// Hashed set of 32-bit unsigned keys: bucket = key mod BUCKETS, up to WAYS keys
// per bucket. in_kind selects insert or find; each item yields one result with
// found, stored and bucket_full. After reset the block sweeps the valid rows of
// the table, one bucket per cycle, and holds in_stall high until the sweep ends.
// With BUCKETS a power of two an item is accepted with the row read, then
// compared and written back; otherwise the bucket comes from a multiply by
// the reciprocal of BUCKETS, a multiply back and one corrective subtract, and an
// item passes accept, 3 remainder steps, row read, compare and write back.
// The registered row read of the bucket memory makes compare a step of its own.
// Results sit in an output register, so one finished result waits for its
// transfer while the next item is taken; that item then holds in compare until
// the waiting result leaves.
module hash_set_insert_find_core #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [31:0] in_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic        out_stored,
  output logic        out_bucket_full
);

  hsif_pkg::ctrl_cmd_t    cmd;
  hsif_pkg::ctrl_status_t status;

  hsif_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  hsif_dp #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_kind         (in_kind),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_stored      (out_stored),
    .out_bucket_full (out_bucket_full)
  );

endmodule

/* hdl/hsif_ram.sv */
module hsif_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write one row, read one row with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/hsif_ctrl.sv */
module hsif_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output hsif_pkg::ctrl_cmd_t   cmd,
  input  hsif_pkg::ctrl_status_t status
);

  hsif_pkg::ctrl_state_t state_r;
  hsif_pkg::ctrl_state_t state_nxt;

  // advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsif_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hsif_pkg::ST_CLEAR: begin
        if (status.clr_last) state_nxt = hsif_pkg::ST_IDLE;
      end
      hsif_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.hash_direct ? hsif_pkg::ST_CMP : hsif_pkg::ST_DIV;
        end
      end
      hsif_pkg::ST_DIV: begin
        if (status.div_last) state_nxt = hsif_pkg::ST_LOOK;
      end
      hsif_pkg::ST_LOOK: begin
        state_nxt = hsif_pkg::ST_CMP;
      end
      hsif_pkg::ST_CMP: begin
        if (!status.out_busy) state_nxt = hsif_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = hsif_pkg::ST_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      hsif_pkg::ST_CLEAR: begin
        cmd.clr_we = 1'b1;
      end
      hsif_pkg::ST_IDLE: begin
        in_stall         = 1'b0;
        cmd.accept       = in_valid;
        cmd.addr_from_in = 1'b1;
      end
      hsif_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      hsif_pkg::ST_LOOK: begin
        cmd = '0;
      end
      hsif_pkg::ST_CMP: begin
        cmd.commit = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // a direct-hash item reaches the compare state in the next cycle
  a_direct_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && status.hash_direct |=> state_r == hsif_pkg::ST_CMP)
    else $error("direct hash item did not reach compare");

  // the last remainder step is followed by the row read
  a_div_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hsif_pkg::ST_DIV && status.div_last |=> state_r == hsif_pkg::ST_LOOK)
    else $error("remainder did not end in row read");

  // the clearing pass ends only on its last row
  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hsif_pkg::ST_CLEAR && !status.clr_last |=> state_r == hsif_pkg::ST_CLEAR)
    else $error("clearing pass left early");

endmodule

/* hdl/hsif_dp.sv */
module hsif_dp #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hsif_pkg::ctrl_cmd_t    cmd,
  output hsif_pkg::ctrl_status_t status,
  input  logic                   in_kind,
  input  logic [hsif_pkg::KEY_W-1:0] in_key,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_found,
  output logic                   out_stored,
  output logic                   out_bucket_full
);

  localparam int  BW          = $clog2(BUCKETS);
  localparam int  ROW_W       = WAYS * hsif_pkg::KEY_W;
  localparam bit  HASH_DIRECT = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam logic [63:0] RECIP_W = (64'd1 << hsif_pkg::KEY_W) / 64'(BUCKETS);
  localparam logic [hsif_pkg::KEY_W-1:0] RECIP = RECIP_W[hsif_pkg::KEY_W-1:0];
  localparam logic [hsif_pkg::KEY_W-1:0] BKT_K = hsif_pkg::KEY_W'(BUCKETS);
  localparam logic [BW-1:0] BKT_LAST = BW'(BUCKETS - 1);
  localparam logic [hsif_pkg::CNT_W-1:0] DIV_LAST =
    hsif_pkg::CNT_W'(hsif_pkg::DIV_STEPS - 1);

  logic                       kind_r;
  logic [hsif_pkg::KEY_W-1:0] key_r;
  logic [BW-1:0]              bucket_r;
  logic [hsif_pkg::KEY_W-1:0] quo_r;
  logic [hsif_pkg::KEY_W-1:0] qd_r;
  logic [hsif_pkg::CNT_W-1:0] cnt_r;
  logic [BW-1:0]              clr_cnt_r;
  logic                       out_valid_r;
  logic                       out_found_r;
  logic                       out_stored_r;
  logic                       out_full_r;

  logic [2*hsif_pkg::KEY_W-1:0] prod;
  logic [hsif_pkg::KEY_W-1:0]   diff;
  logic [BW-1:0]    rem_nxt;
  logic [BW-1:0]    raddr;
  logic [ROW_W-1:0] key_rd;
  logic [WAYS-1:0]  valid_rd;
  logic [WAYS-1:0]  hit_vec;
  logic [WAYS-1:0]  free_vec;
  logic [WAYS-1:0]  free_oh;
  logic             hit;
  logic             have_free;
  logic             do_store;
  logic             is_insert;
  logic [ROW_W-1:0] key_row_nxt;
  logic             valid_we;
  logic [BW-1:0]    valid_waddr;
  logic [WAYS-1:0]  valid_wdata;

  // quotient estimate from the reciprocal falls short by at most one,
  // so the remainder needs one corrective subtract
  always_comb begin
    prod    = {{hsif_pkg::KEY_W{1'b0}}, key_r} * {{hsif_pkg::KEY_W{1'b0}}, RECIP};
    diff    = key_r - qd_r;
    rem_nxt = (diff >= BKT_K) ? BW'(diff - BKT_K) : diff[BW-1:0];
  end

  // capture the item and run the bucket remainder
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r   <= in_kind;
      key_r    <= in_key;
      bucket_r <= in_key[BW-1:0];
      cnt_r    <= '0;
    end else if (cmd.div_step) begin
      quo_r <= prod[2*hsif_pkg::KEY_W-1:hsif_pkg::KEY_W];
      qd_r  <= quo_r * BKT_K;
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_LAST) bucket_r <= rem_nxt;
    end
  end

  // sweep the valid rows after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign raddr = cmd.addr_from_in ? in_key[BW-1:0] : bucket_r;

  // compare all ways and pick the lowest free way
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = valid_rd[w] && (key_rd[w*hsif_pkg::KEY_W +: hsif_pkg::KEY_W] == key_r);
    end
    free_vec  = ~valid_rd;
    free_oh   = free_vec & (~free_vec + 1'b1);
    hit       = |hit_vec;
    have_free = |free_vec;
    is_insert = kind_r == hsif_pkg::KIND_INSERT;
    do_store  = is_insert && !hit && have_free;
  end

  // build the updated key row
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      key_row_nxt[w*hsif_pkg::KEY_W +: hsif_pkg::KEY_W] =
        free_oh[w] ? key_r : key_rd[w*hsif_pkg::KEY_W +: hsif_pkg::KEY_W];
    end
  end

  assign valid_we    = cmd.clr_we || (cmd.commit && do_store);
  assign valid_waddr = cmd.clr_we ? clr_cnt_r : bucket_r;
  assign valid_wdata = cmd.clr_we ? '0 : (valid_rd | free_oh);

  hsif_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.commit && do_store),
    .waddr (bucket_r),
    .wdata (key_row_nxt),
    .raddr (raddr),
    .rdata (key_rd)
  );

  hsif_ram #(
    .WIDTH (WAYS),
    .DEPTH (BUCKETS)
  ) u_valid_ram (
    .clk   (clk),
    .we    (valid_we),
    .waddr (valid_waddr),
    .wdata (valid_wdata),
    .raddr (raddr),
    .rdata (valid_rd)
  );

  // load the result register, drop it after its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_found_r  <= hit;
      out_stored_r <= do_store;
      out_full_r   <= is_insert && !hit && !have_free;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_stored      = out_stored_r;
  assign out_bucket_full = out_full_r;

  assign status.clr_last    = clr_cnt_r == BKT_LAST;
  assign status.div_last    = cnt_r == DIV_LAST;
  assign status.hash_direct = HASH_DIRECT;
  assign status.out_busy    = out_valid_r && out_stall;

  // a find never writes the table
  a_find_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && kind_r == hsif_pkg::KIND_FIND |-> !do_store)
    else $error("find wrote the table");

  // no commit while the clearing pass runs
  a_clear_no_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_we |-> !cmd.commit && !cmd.accept)
    else $error("item handled during clearing pass");

  // a result is one of hit, stored or full at most
  a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_found, out_stored, out_bucket_full}) <= 1)
    else $error("result flags overlap");

  // a commit never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

endmodule

/* bench/hash_set_insert_find_core_test.sv */
`timescale 1ns / 1ps

module hash_set_insert_find_core_test;

  localparam int BUCKETS    = 1024;
  localparam int WAYS       = 4;
  localparam int RAND_ITEMS = 750;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOT_COUNT  = 12;
  localparam int HI_COUNT   = 6;

  // one answer of the set: key seen before, key added, bucket rejected it
  typedef struct packed {
    logic found;
    logic stored;
    logic bucket_full;
  } answer_t;

  // Shadow copy of the hashed set; predicts the answer of every accepted transfer.
  class key_set_shadow;
    int unsigned n_buckets;
    int unsigned n_ways;
    logic [31:0] slot_key[];
    bit          slot_live[];
    answer_t     pending_answers[$];
    int errors;
    int n_items, n_stored, n_dups, n_full, n_finds, n_hits;

    function new(int unsigned buckets, int unsigned ways);
      n_buckets = buckets;
      n_ways    = ways;
      slot_key  = new[buckets * ways];
      slot_live = new[buckets * ways];
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      errors = 0;
      n_items = 0; n_stored = 0; n_dups = 0; n_full = 0; n_finds = 0; n_hits = 0;
    endfunction

    // Look the key up, apply an insert and queue the answer.
    function void log_request(logic kind, logic [31:0] key);
      int unsigned base;
      int unsigned free_way;
      bit hit;
      bit have_free;
      answer_t ans;
      base = (key % n_buckets) * n_ways;
      hit = 1'b0;
      have_free = 1'b0;
      free_way = 0;
      for (int unsigned w = 0; w < n_ways; w++) begin
        if (slot_live[base + w]) begin
          if (slot_key[base + w] == key) hit = 1'b1;
        end else if (!have_free) begin
          have_free = 1'b1;
          free_way = w;
        end
      end
      ans = '0;
      ans.found = hit;
      if (kind == hsif_pkg::KIND_INSERT && !hit) begin
        if (have_free) begin
          slot_key[base + free_way]  = key;
          slot_live[base + free_way] = 1'b1;
          ans.stored = 1'b1;
        end else begin
          ans.bucket_full = 1'b1;
        end
      end
      n_items++;
      if (kind == hsif_pkg::KIND_FIND) begin
        n_finds++;
        if (hit) n_hits++;
      end else begin
        if (hit) n_dups++;
        if (ans.stored) n_stored++;
        if (ans.bucket_full) n_full++;
      end
      pending_answers.push_back(ans);
    endfunction

    function void check_bit(string field, logic want, logic got);
      if (got !== want) begin
        errors++;
        if (errors <= 30)
          $display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, want, got);
      end
    endfunction

    // Compare one result transfer with the oldest queued answer.
    function void match_reply(logic found, logic stored, logic bucket_full);
      answer_t want;
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: result with no item pending, expected none, actual %0b%0b%0b",
                   $time, found, stored, bucket_full);
        return;
      end
      want = pending_answers.pop_front();
      check_bit("found", want.found, found);
      check_bit("stored", want.stored, stored);
      check_bit("bucket_full", want.bucket_full, bucket_full);
    endfunction
  endclass

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_kind         = hsif_pkg::KIND_INSERT;
  logic [31:0] in_key          = '0;
  logic        out_stall       = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_found;
  logic        out_stored;
  logic        out_bucket_full;

  key_set_shadow shadow = new(BUCKETS, WAYS);

  bit send_lazy = 1'b0;
  int items_sent = 0;
  int idle_cycles = 0;

  int unsigned hot_bucket[HOT_COUNT];
  int unsigned hi_part[HI_COUNT];

  hash_set_insert_find_core #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_stored     (out_stored),
    .out_bucket_full(out_bucket_full)
  );

  always #10 clk = ~clk;

  // Offer one item after a drawn gap and hold it until the transfer.
  task automatic send_item(input logic kind, input logic [31:0] key);
    int gap;
    gap = send_lazy ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_key   <= key;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    shadow.log_request(kind, key);
    items_sent++;
    if (items_sent % 43 == 0) send_lazy = ($urandom_range(0, 2) != 0);
  endtask

  // Key from the hot pool: few buckets, few upper parts, so buckets fill up.
  function automatic logic [31:0] hot_key();
    longint unsigned k;
    k = longint'(hi_part[$urandom_range(0, HI_COUNT - 1)]) * BUCKETS
        + hot_bucket[$urandom_range(0, HOT_COUNT - 1)];
    return k[31:0];
  endfunction

  task automatic run_directed();
    // empty table, then a duplicate on bucket zero
    send_item(hsif_pkg::KIND_FIND,   32'h0000_0000);
    send_item(hsif_pkg::KIND_INSERT, 32'h0000_0000);
    send_item(hsif_pkg::KIND_INSERT, 32'h0000_0000);
    send_item(hsif_pkg::KIND_FIND,   32'h0000_0000);
    send_item(hsif_pkg::KIND_INSERT, 32'hFFFF_FFFF);
    send_item(hsif_pkg::KIND_FIND,   32'hFFFF_FFFF);
    send_item(hsif_pkg::KIND_FIND,   32'hFFFF_FC00);
    // fill bucket five, then overflow it
    send_item(hsif_pkg::KIND_INSERT, 32'h0000_0005);
    send_item(hsif_pkg::KIND_INSERT, 32'h0000_0405);
    send_item(hsif_pkg::KIND_INSERT, 32'h8000_0005);
    send_item(hsif_pkg::KIND_INSERT, 32'hFFFF_FC05);
    send_item(hsif_pkg::KIND_INSERT, 32'h0000_0805);
    send_item(hsif_pkg::KIND_INSERT, 32'h8000_0005);
    send_item(hsif_pkg::KIND_FIND,   32'h0000_0805);
    send_item(hsif_pkg::KIND_FIND,   32'hFFFF_FC05);
    // second way of the top bucket and alternating bit patterns
    send_item(hsif_pkg::KIND_INSERT, 32'h7FFF_FFFF);
    send_item(hsif_pkg::KIND_FIND,   32'hAAAA_AAAA);
    send_item(hsif_pkg::KIND_INSERT, 32'h5555_5555);
    send_item(hsif_pkg::KIND_FIND,   32'h5555_5555);
    send_item(hsif_pkg::KIND_INSERT, 32'hAAAA_AAAA);
    send_item(hsif_pkg::KIND_FIND,   32'hAAAA_AAAA);
  endtask

  task automatic run_random();
    logic kind;
    logic [31:0] key;
    foreach (hot_bucket[i]) hot_bucket[i] = $urandom_range(0, BUCKETS - 1);
    foreach (hi_part[i]) hi_part[i] = $urandom_range(0, 32'hFFFF_FFFF / BUCKETS);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      kind = ($urandom_range(0, 99) < 55) ? hsif_pkg::KIND_INSERT : hsif_pkg::KIND_FIND;
      key  = ($urandom_range(0, 4) == 0) ? $urandom() : hot_key();
      send_item(kind, key);
    end
  endtask

  // Stimulus and end of run.
  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (shadow.pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d items: %0d stored, %0d duplicate inserts, %0d full-bucket rejects,",
             shadow.n_items, shadow.n_stored, shadow.n_dups, shadow.n_full);
    $display("  %0d finds with %0d hits, one long output stall with the input backed up.",
             shadow.n_finds, shadow.n_hits);
    if (shadow.errors == 0 && shadow.pending_answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: random stalls, idle-free stretches and one long hold-off.
  initial begin : drain
    int n_seen;
    int hold;
    bit lazy;
    n_seen = 0;
    lazy = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (n_seen % 37 == 0) lazy = ($urandom_range(0, 2) != 0);
      hold = (n_seen == 200) ? 250 : (lazy ? $urandom_range(0, 11) : 0);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      shadow.match_reply(out_found, out_stored, out_bucket_full);
      n_seen++;
    end
  end

  // Stop a hung run: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
